// ===== design/bbt_pkg.sv =====
`default_nettype none

package bbt_pkg;

    // Operation codes carried in the func field
    localparam logic [2:0] F_WR_OWN  = 3'd0;
    localparam logic [2:0] F_WR_PEER = 3'd1;
    localparam logic [2:0] F_WR_SUB  = 3'd2;
    localparam logic [2:0] F_DEL_OWN  = 3'd3;
    localparam logic [2:0] F_DEL_PEER = 3'd4;
    localparam logic [2:0] F_DEL_SUB  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam int KEY_W = 50;

    // One request word
    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  addr_type;
        logic [47:0] dev_addr;
        logic [15:0] char_handle;
        logic [7:0]  key_index;
        logic [63:0] payload;
    } t_bbt_req;

    // One result word
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
        logic       has_bond;
        logic [1:0] own_count;
        logic [1:0] peer_entries;
        logic [3:0] sub_count;
    } t_bbt_rsp;

    // One stored table entry (bond entries leave the handle unused)
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [15:0]      handle;
        logic [63:0]      data;
    } t_bbt_entry;

endpackage

`default_nettype wire

// ===== design/bbt_ram.sv =====
`default_nettype none

module bbt_ram #(
    parameter int WIDTH = 130,
    parameter int DEPTH = 14
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/bounded_bond_table_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Word
// request   in         start high, busy low       i_req (bbt_pkg::t_bbt_req)
// result    out        o_done, one cycle          o_rsp (bbt_pkg::t_bbt_rsp)
//
// All three tables live in one memory with a registered read port; the
// sequencer reads then checks each entry scanned (S_READ, S_CHECK) and
// reads then writes each entry shifted (S_SHRD, S_SHWR); the scan covers
// the entry count of the table addressed (at most SUB_SLOTS).
// Reset empties all tables at once by clearing the counts; no memory pass.
// Results cannot be stalled; busy stays high until the result strobe.
module bounded_bond_table_unit #(
    parameter int BOND_SLOTS = 3,
    parameter int SUB_SLOTS  = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire bbt_pkg::t_bbt_req  i_req,
    output logic                    o_done,
    output bbt_pkg::t_bbt_rsp       o_rsp
);

    import bbt_pkg::*;

    localparam int DEPTH = 2 * BOND_SLOTS + SUB_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXS  = (SUB_SLOTS > BOND_SLOTS) ? SUB_SLOTS : BOND_SLOTS;
    localparam int CW    = $clog2(MAXS + 1);
    localparam int BCW   = $clog2(BOND_SLOTS + 1);
    localparam int SCW   = $clog2(SUB_SLOTS + 1);
    localparam int CMPW  = (CW > 8) ? CW : 8;
    localparam int EW    = $bits(t_bbt_entry);

    localparam logic [AW-1:0] BASE_OWN  = AW'(0);
    localparam logic [AW-1:0] BASE_PEER = AW'(BOND_SLOTS);
    localparam logic [AW-1:0] BASE_SUB  = AW'(2 * BOND_SLOTS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_SHRD  = 7'b0010000,
        S_SHWR  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    t_bbt_req          r_req, n_req;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_seen, n_seen;
    logic [BCW-1:0]    r_own_cnt, n_own_cnt;
    logic [BCW-1:0]    r_peer_cnt, n_peer_cnt;
    logic [SCW-1:0]    r_sub_cnt, n_sub_cnt;
    logic [1:0]        r_status, n_status;
    logic [2:0]        r_slot, n_slot;
    logic              r_done, n_done;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    t_bbt_entry        mem_wdata;
    logic [EW-1:0]     mem_rdata;
    t_bbt_entry        ent;

    t_bbt_req          req_c;
    logic [KEY_W-1:0]  key_c;
    logic              accept;
    logic              sel_own, sel_peer, sel_sub, is_write;
    logic [CW-1:0]     cur_cnt;
    logic              cur_full;
    logic [AW-1:0]     base;
    logic [CW-1:0]     idx_inc;
    logic              key_eq, h_eq, sub_match, hit;
    logic [CW+2:0]     pos_ext;

    // Table storage
    bbt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign ent    = t_bbt_entry'(mem_rdata);
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Decode the word being worked on: the incoming one while idle
    assign req_c    = (r_state == S_IDLE) ? i_req : r_req;
    assign key_c    = {req_c.addr_type, req_c.dev_addr};
    assign sel_own  = (req_c.func == F_WR_OWN) || (req_c.func == F_DEL_OWN);
    assign sel_peer = (req_c.func == F_WR_PEER) || (req_c.func == F_DEL_PEER);
    assign sel_sub  = (req_c.func == F_WR_SUB) || (req_c.func == F_DEL_SUB);
    assign is_write = (req_c.func == F_WR_OWN) || (req_c.func == F_WR_PEER)
                   || (req_c.func == F_WR_SUB);

    always_comb begin
        if (sel_own) begin
            cur_cnt = CW'(r_own_cnt);
            base    = BASE_OWN;
        end else if (sel_peer) begin
            cur_cnt = CW'(r_peer_cnt);
            base    = BASE_PEER;
        end else begin
            cur_cnt = CW'(r_sub_cnt);
            base    = BASE_SUB;
        end
    end

    assign cur_full = sel_sub ? (cur_cnt == CW'(SUB_SLOTS)) : (cur_cnt == CW'(BOND_SLOTS));
    assign idx_inc  = r_idx + 1'b1;

    // Compare the entry just read against the request
    assign key_eq    = (ent.key == key_c);
    assign h_eq      = (ent.handle == req_c.char_handle);
    assign sub_match = ((key_c == '0) || key_eq) && ((req_c.char_handle == '0) || h_eq);

    always_comb begin
        case (req_c.func)
            F_WR_OWN, F_WR_PEER, F_DEL_OWN, F_DEL_PEER: hit = key_eq;
            F_WR_SUB:  hit = key_eq && h_eq;
            F_DEL_SUB: hit = sub_match && (CMPW'(r_seen) == CMPW'(req_c.key_index));
            default:   hit = 1'b0;
        endcase
    end

    // Sequencer: scan, then update in place, append or shift down
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_seen     = r_seen;
        n_own_cnt  = r_own_cnt;
        n_peer_cnt = r_peer_cnt;
        n_sub_cnt  = r_sub_cnt;
        n_status   = r_status;
        n_slot     = r_slot;
        n_done     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = base + AW'(r_idx);
        mem_wdata  = ent;
        mem_raddr  = base + AW'(r_idx);
        pos_ext    = {3'b000, r_pos};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req    = i_req;
                    n_idx    = '0;
                    n_seen   = '0;
                    n_status = ST_DONE;
                    n_slot   = '0;
                    case (i_req.func)
                        F_WR_OWN, F_WR_PEER, F_WR_SUB, F_DEL_SUB: begin
                            n_state = S_READ;
                        end
                        F_DEL_OWN, F_DEL_PEER: begin
                            if (key_c == '0) begin
                                // wildcard key: remove by position
                                if (CMPW'(i_req.key_index) < CMPW'(cur_cnt)) begin
                                    n_pos   = CW'(i_req.key_index);
                                    n_idx   = CW'(i_req.key_index);
                                    n_state = S_SHRD;
                                end else begin
                                    n_status = ST_NOT_FOUND;
                                    n_state  = S_FIN;
                                end
                            end else if (i_req.key_index != '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_READ: begin
                if (r_idx == cur_cnt) begin
                    // scan ended without a hit
                    if (is_write && !cur_full) begin
                        n_pos   = cur_cnt;
                        n_state = S_WRITE;
                    end else begin
                        n_status = is_write ? ST_FULL : ST_NOT_FOUND;
                        n_state  = S_FIN;
                    end
                end else begin
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                if (hit) begin
                    n_pos   = r_idx;
                    n_state = is_write ? S_WRITE : S_SHRD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_READ;
                    if (sub_match) begin
                        n_seen = r_seen + 1'b1;
                    end
                end
            end

            S_WRITE: begin
                mem_we           = 1'b1;
                mem_waddr        = base + AW'(r_pos);
                mem_wdata.key    = key_c;
                mem_wdata.handle = req_c.char_handle;
                mem_wdata.data   = req_c.payload;
                if (r_pos == cur_cnt) begin
                    if (sel_own) begin
                        n_own_cnt = r_own_cnt + 1'b1;
                    end else if (sel_peer) begin
                        n_peer_cnt = r_peer_cnt + 1'b1;
                    end else begin
                        n_sub_cnt = r_sub_cnt + 1'b1;
                    end
                end
                n_slot  = pos_ext[2:0];
                n_state = S_FIN;
            end

            S_SHRD: begin
                mem_raddr = base + AW'(idx_inc);
                if (idx_inc < cur_cnt) begin
                    n_state = S_SHWR;
                end else begin
                    // compaction done: drop the last entry
                    if (sel_own) begin
                        n_own_cnt = r_own_cnt - 1'b1;
                    end else if (sel_peer) begin
                        n_peer_cnt = r_peer_cnt - 1'b1;
                    end else begin
                        n_sub_cnt = r_sub_cnt - 1'b1;
                    end
                    n_slot  = pos_ext[2:0];
                    n_state = S_FIN;
                end
            end

            S_SHWR: begin
                mem_we    = 1'b1;
                mem_waddr = base + AW'(r_idx);
                mem_wdata = ent;
                n_idx     = idx_inc;
                n_state   = S_SHRD;
            end

            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_own_cnt  <= '0;
            r_peer_cnt <= '0;
            r_sub_cnt  <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_own_cnt  <= n_own_cnt;
            r_peer_cnt <= n_peer_cnt;
            r_sub_cnt  <= n_sub_cnt;
            r_done     <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_seen   <= n_seen;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    // Result word
    logic [BCW+1:0] own_ext, peer_ext;
    logic [SCW+3:0] sub_ext;

    assign own_ext  = {2'b00, r_own_cnt};
    assign peer_ext = {2'b00, r_peer_cnt};
    assign sub_ext  = {4'b0000, r_sub_cnt};

    assign o_done             = r_done;
    assign o_rsp.status       = r_status;
    assign o_rsp.slot         = r_slot;
    assign o_rsp.has_bond     = (r_own_cnt != '0) || (r_peer_cnt != '0);
    assign o_rsp.own_count    = own_ext[1:0];
    assign o_rsp.peer_entries = peer_ext[1:0];
    assign o_rsp.sub_count    = sub_ext[3:0];

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN))
        else $error("result strobe outside of finish step");

    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_DONE) |-> (o_rsp.slot == '0))
        else $error("failed operation reports a slot");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_own_cnt <= BCW'(BOND_SLOTS)) && (r_peer_cnt <= BCW'(BOND_SLOTS))
        && (r_sub_cnt <= SCW'(SUB_SLOTS)))
        else $error("table count above capacity");

endmodule

`default_nettype wire

// ===== test/bbt_result_checker.sv =====
// Watch the request and result channels, keep a shadow copy of the three
// tables, and compare every result word against the oldest prediction.
module bbt_result_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire bbt_pkg::t_bbt_req i_req,
    input  wire logic              i_done,
    input  wire bbt_pkg::t_bbt_rsp i_rsp,
    output int                     o_pending,
    output int                     o_fail_count
);

    import bbt_pkg::*;

    localparam int BOND_SLOTS = 3;
    localparam int SUB_SLOTS  = 8;
    localparam int OWN_TBL    = 0;
    localparam int PEER_TBL   = 1;

    // Shadow tables; only entries below the counts are ever looked at
    logic [KEY_W-1:0] bond_key  [2][BOND_SLOTS];
    logic [63:0]      bond_data [2][BOND_SLOTS];
    int               bond_cnt  [2] = '{0, 0};
    logic [KEY_W-1:0] sub_key   [SUB_SLOTS];
    logic [15:0]      sub_hdl   [SUB_SLOTS];
    logic [63:0]      sub_data  [SUB_SLOTS];
    int               sub_cnt = 0;

    t_bbt_rsp expected_rsp [$];
    int       pending_total = 0;
    int       fail_total = 0;

    assign o_pending    = pending_total;
    assign o_fail_count = fail_total;

    // Apply one request word to the shadow tables and return its result word
    function automatic t_bbt_rsp predict_word(t_bbt_req r);
        t_bbt_rsp         rsp;
        logic [KEY_W-1:0] key;
        logic [1:0]       status;
        int               tbl;
        int               pos;
        int               found;
        int               seen;
        key    = {r.addr_type, r.dev_addr};
        tbl    = (r.func == F_WR_PEER || r.func == F_DEL_PEER) ? PEER_TBL : OWN_TBL;
        status = ST_DONE;
        pos    = 0;
        found  = -1;
        seen   = 0;
        case (r.func)
            F_WR_OWN, F_WR_PEER: begin
                // Update a matching key, else append, else drop when full
                for (int i = 0; i < bond_cnt[tbl]; i++)
                    if (found < 0 && bond_key[tbl][i] == key)
                        found = i;
                if (found >= 0) begin
                    bond_data[tbl][found] = r.payload;
                    pos = found;
                end else if (bond_cnt[tbl] >= BOND_SLOTS) begin
                    status = ST_FULL;
                end else begin
                    pos = bond_cnt[tbl];
                    bond_key[tbl][pos]  = key;
                    bond_data[tbl][pos] = r.payload;
                    bond_cnt[tbl]++;
                end
            end
            F_DEL_OWN, F_DEL_PEER: begin
                // Wildcard key selects by index; a real key needs index zero
                found = bond_cnt[tbl];
                if (key == '0) begin
                    if (int'(r.key_index) < bond_cnt[tbl])
                        found = int'(r.key_index);
                end else if (r.key_index == '0) begin
                    for (int i = 0; i < bond_cnt[tbl]; i++)
                        if (found == bond_cnt[tbl] && bond_key[tbl][i] == key)
                            found = i;
                end
                if (found >= bond_cnt[tbl]) begin
                    status = ST_NOT_FOUND;
                end else begin
                    for (int i = found; i + 1 < bond_cnt[tbl]; i++) begin
                        bond_key[tbl][i]  = bond_key[tbl][i + 1];
                        bond_data[tbl][i] = bond_data[tbl][i + 1];
                    end
                    bond_cnt[tbl]--;
                    pos = found;
                end
            end
            F_WR_SUB: begin
                for (int i = 0; i < sub_cnt; i++)
                    if (found < 0 && sub_key[i] == key && sub_hdl[i] == r.char_handle)
                        found = i;
                if (found >= 0) begin
                    sub_data[found] = r.payload;
                    pos = found;
                end else if (sub_cnt >= SUB_SLOTS) begin
                    status = ST_FULL;
                end else begin
                    pos = sub_cnt;
                    sub_key[pos]  = key;
                    sub_hdl[pos]  = r.char_handle;
                    sub_data[pos] = r.payload;
                    sub_cnt++;
                end
            end
            F_DEL_SUB: begin
                // Take the n-th match; zero key or zero handle matches anything
                found = sub_cnt;
                for (int i = 0; i < sub_cnt; i++) begin
                    if (found == sub_cnt && (key == '0 || sub_key[i] == key) &&
                        (r.char_handle == '0 || sub_hdl[i] == r.char_handle)) begin
                        if (seen == int'(r.key_index))
                            found = i;
                        seen++;
                    end
                end
                if (found >= sub_cnt) begin
                    status = ST_NOT_FOUND;
                end else begin
                    for (int i = found; i + 1 < sub_cnt; i++) begin
                        sub_key[i]  = sub_key[i + 1];
                        sub_hdl[i]  = sub_hdl[i + 1];
                        sub_data[i] = sub_data[i + 1];
                    end
                    sub_cnt--;
                    pos = found;
                end
            end
            default: begin
                // Unused codes leave every table alone
            end
        endcase
        if (status != ST_DONE)
            pos = 0;
        rsp.status       = status;
        rsp.slot         = 3'(pos);
        rsp.has_bond     = (bond_cnt[OWN_TBL] != 0 || bond_cnt[PEER_TBL] != 0);
        rsp.own_count    = 2'(bond_cnt[OWN_TBL]);
        rsp.peer_entries = 2'(bond_cnt[PEER_TBL]);
        rsp.sub_count    = 4'(sub_cnt);
        return rsp;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    // Retire result words first, then queue the prediction for a new word
    always @(posedge i_clk) begin : watch_words
        t_bbt_rsp want;
        if (!i_rst_n) begin
            bond_cnt[OWN_TBL]  = 0;
            bond_cnt[PEER_TBL] = 0;
            sub_cnt = 0;
            expected_rsp.delete();
        end else begin
            if (i_done) begin
                if (expected_rsp.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    fail_total++;
                end else begin
                    want = expected_rsp.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("slot", want.slot, i_rsp.slot);
                    check_field("has_bond", want.has_bond, i_rsp.has_bond);
                    check_field("own_count", want.own_count, i_rsp.own_count);
                    check_field("peer_entries", want.peer_entries, i_rsp.peer_entries);
                    check_field("sub_count", want.sub_count, i_rsp.sub_count);
                end
            end
            if (i_start && !i_busy)
                expected_rsp.push_back(predict_word(i_req));
        end
        pending_total <= expected_rsp.size();
    end

endmodule

// ===== test/tb_bounded_bond_table_unit.sv =====
module tb_bounded_bond_table_unit;
    import bbt_pkg::*;

    // Codes outside the defined operations
    localparam logic [2:0] F_SPARE_6 = 3'd6;
    localparam logic [2:0] F_SPARE_7 = 3'd7;

    localparam int ITEMS_PER_PHASE = 600;
    localparam int MAX_GAP         = 60;
    localparam int DRAIN_CYCLES    = 40;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_bbt_req i_req   = '0;
    logic     busy;
    logic     o_done;
    t_bbt_rsp o_rsp;
    int       pending_words;
    int       fail_count;
    int       idle_pct = 8;

    // Small pools so that writes and deletes keep hitting the same entries
    logic [KEY_W-1:0] key_pool    [6];
    logic [15:0]      handle_pool [4];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bounded_bond_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    bbt_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .o_pending    (pending_words),
        .o_fail_count (fail_count)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_bbt_req make_word(logic [2:0] func, logic [KEY_W-1:0] key,
                                           logic [15:0] handle, logic [7:0] idx,
                                           logic [63:0] payload);
        t_bbt_req w;
        w.func                  = func;
        {w.addr_type, w.dev_addr} = key;
        w.char_handle           = handle;
        w.key_index             = idx;
        w.payload               = payload;
        return w;
    endfunction

    // Mostly pooled keys and handles with small indexes; a few raw words
    function automatic t_bbt_req random_word();
        logic [2:0]       func;
        logic [KEY_W-1:0] key;
        logic [15:0]      handle;
        logic [7:0]       idx;
        int               pick;
        if ($urandom_range(99) < 8)
            return make_word(3'($urandom_range(7)), {2'($urandom_range(3)), 48'(rand64())},
                             16'($urandom), 8'($urandom), rand64());
        pick = $urandom_range(99);
        if (pick < 18)
            func = F_WR_OWN;
        else if (pick < 36)
            func = F_WR_PEER;
        else if (pick < 58)
            func = F_WR_SUB;
        else if (pick < 70)
            func = F_DEL_OWN;
        else if (pick < 82)
            func = F_DEL_PEER;
        else if (pick < 97)
            func = F_DEL_SUB;
        else
            func = ($urandom_range(1) != 0) ? F_SPARE_7 : F_SPARE_6;
        key    = key_pool[$urandom_range(5)];
        handle = handle_pool[$urandom_range(3)];
        idx    = 8'($urandom_range(3));
        if (func == F_DEL_OWN || func == F_DEL_PEER) begin
            if ($urandom_range(99) < 40)
                key = '0;
            else if ($urandom_range(99) < 85)
                idx = '0;
        end else if (func == F_DEL_SUB) begin
            if ($urandom_range(99) < 35)
                key = '0;
            if ($urandom_range(99) < 35)
                handle = '0;
            idx = 8'($urandom_range(4));
        end
        if ($urandom_range(99) < 5)
            idx = 8'($urandom);
        return make_word(func, key, handle, idx, rand64());
    endfunction

    // Hold the word until accepted, then maybe leave start low for a while
    task automatic send_word(t_bbt_req w);
        int gap;
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and hold off until every result word is back
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    initial begin
        key_pool[0] = {2'b11, 48'hFFFF_FFFF_FFFF};
        for (int i = 1; i < 6; i++)
            key_pool[i] = {2'($urandom_range(3)), 48'(rand64())};
        handle_pool[0] = 16'h0001;
        handle_pool[1] = 16'hFFFF;
        handle_pool[2] = 16'($urandom);
        handle_pool[3] = 16'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Own table: fill, update, zero key, full, every delete flavor
        send_word(make_word(F_WR_OWN, key_pool[0], '0, '0, '1));
        send_word(make_word(F_WR_OWN, key_pool[1], '0, '0, '0));
        send_word(make_word(F_WR_OWN, key_pool[0], '0, '0, rand64()));
        send_word(make_word(F_WR_OWN, '0, '0, '0, rand64()));
        send_word(make_word(F_WR_OWN, key_pool[2], '0, '0, rand64()));
        send_word(make_word(F_DEL_OWN, '0, '0, 8'd7, rand64()));
        send_word(make_word(F_DEL_OWN, key_pool[1], '0, 8'd1, '0));
        send_word(make_word(F_DEL_OWN, key_pool[1], '0, '0, '0));
        send_word(make_word(F_DEL_OWN, '0, '0, '0, '0));
        // Peer table: one write, then a miss
        send_word(make_word(F_WR_PEER, key_pool[0], '1, '1, rand64()));
        send_word(make_word(F_DEL_PEER, key_pool[2], '0, '0, '0));
        // Subscriptions: fill all slots, overflow, then wildcard deletes
        for (int i = 0; i < 8; i++)
            send_word(make_word(F_WR_SUB, key_pool[i / 4], handle_pool[i % 4], '0, rand64()));
        send_word(make_word(F_WR_SUB, key_pool[2], 16'hFFFF, '0, rand64()));
        send_word(make_word(F_DEL_SUB, '0, '0, 8'hFF, '0));
        send_word(make_word(F_DEL_SUB, key_pool[0], '0, 8'd1, '0));
        send_word(make_word(F_DEL_SUB, '0, handle_pool[2], '0, '0));
        // Unused codes
        send_word(make_word(F_SPARE_6, key_pool[1], '1, 8'hFF, '1));
        send_word(make_word(F_SPARE_7, '1, '1, 8'hFF, '1));
        wait_for_results();

        // Random phases: light sender idling, heavy idling, then none
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 8 : (phase == 1) ? 88 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_word(random_word());
                if ($urandom_range(99) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
